// File: hdl/abls_pkg.sv
`default_nettype none
package abls_pkg;

    localparam int ABLS_MAX_COUNT   = 1024;
    localparam int ABLS_SAMPLE_BITS = 12;

    // fixed widths of the channel fields
    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 11;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_level;
        logic [SAMPLE_W-1:0] span;
        logic [SAMPLE_W-1:0] rms_level;
        logic [COUNT_W-1:0]  samples_seen;
        logic                overflow_flag;
    } t_out_item;

    typedef struct packed {
        logic acc;        // sample transfer this cycle
        logic load;       // the transfer ends the buffer: start the divide
        logic div_step;
        logic mean_step;
        logic root_load;
        logic root_step;
        logic push;       // move the result into the output register
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    typedef enum logic [4:0] {
        S_ACC   = 5'b00001,
        S_DIV   = 5'b00010,
        S_RLOAD = 5'b00100,
        S_ROOT  = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

// File: hdl/audio_buffer_level_stats_unit.sv
// Audio buffer level meter: mean, peak-to-peak span and RMS of a buffer.
//
// Input channel (i_valid/o_ready, i_data): one sample per transfer, the last
// sample of a buffer marked by end_of_buffer. Samples of a running buffer
// are taken one per cycle.
// Output channel (o_valid/i_ready, o_data): one result per buffer.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data): the DC bias used for
// the RMS; always ready, write it only while the block is idle.
//
// After the last sample the input stalls while a shift-subtract divider runs,
// then a load state, a digit-by-digit square root of SAMPLE_BITS result bits,
// and a push into the output register: the result becomes valid and the input
// is ready again in the same cycle.
// The result register lets the next buffer accumulate while a result waits;
// if the receiver still stalls when the next result is done, the block holds
// it and keeps o_ready low. Reset clears the accumulators and the bias and
// drops any pending result.
`default_nettype none
module audio_buffer_level_stats_unit
    import abls_pkg::*;
#(
    parameter int MAX_COUNT   = ABLS_MAX_COUNT,
    parameter int SAMPLE_BITS = ABLS_SAMPLE_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [SAMPLE_W-1:0] i_cfg_data
);

    localparam int SB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int TW = $clog2(MAX_COUNT + 1);

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    abls_ctrl #(
        .DIV_STEPS  (2 * SB + TW),
        .MEAN_STEPS (SB + TW),
        .ROOT_STEPS (SB)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_last  (i_data.end_of_buffer),
        .o_in_ready (o_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    abls_datapath #(
        .MAX_COUNT (MAX_COUNT),
        .SB        (SB),
        .TW        (TW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_data.sample_value),
        .i_cmd       (w_cmd),
        .i_out_ready (i_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_valid),
        .o_out_data  (o_data)
    );

    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: hdl/abls_ctrl.sv
`default_nettype none
module abls_ctrl
    import abls_pkg::*;
#(
    parameter int DIV_STEPS  = 35,
    parameter int MEAN_STEPS = 23,
    parameter int ROOT_STEPS = 12
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    output logic          o_in_ready,
    input  wire t_dp_sts  i_sts,
    output t_ctl_cmd      o_cmd
);

    localparam int CW = $clog2(DIV_STEPS + 1);
    localparam logic [CW-1:0] DIV_LAST  = CW'(DIV_STEPS - 1);
    localparam logic [CW-1:0] ROOT_LAST = CW'(ROOT_STEPS - 1);
    localparam logic [CW-1:0] MEAN_END  = CW'(MEAN_STEPS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_in_last) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = '0;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.mean_step = (r_cnt < MEAN_END);
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_RLOAD;
                end
            end
            S_RLOAD: begin
                o_cmd.root_load = 1'b1;
                n_cnt           = '0;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: hdl/abls_datapath.sv
`default_nettype none
module abls_datapath
    import abls_pkg::*;
#(
    parameter int MAX_COUNT = 1024,
    parameter int SB        = 12,
    parameter int TW        = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [SAMPLE_W-1:0] i_cfg_data,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_ctl_cmd      i_cmd,
    input  wire logic          i_out_ready,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output t_out_item          o_out_data
);

    localparam int WS = SB + TW;
    localparam int WQ = 2 * SB + TW;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_COUNT);

    logic [SAMPLE_W-1:0] r_dc_bias;

    logic [WS-1:0] r_sum,   n_sum;
    logic [WQ-1:0] r_sq,    n_sq;
    logic [SB-1:0] r_min,   n_min;
    logic [SB-1:0] r_max,   n_max;
    logic [TW-1:0] r_tally, n_tally;
    logic          r_sat,   n_sat;

    logic [SB-1:0]   w_s, w_b, w_dev;
    logic [2*SB-1:0] w_prod;
    logic            w_full;

    // divider state: square sum and level sum share the divisor
    logic [TW-1:0] r_div_n;
    logic [TW-1:0] r_qrem, r_mrem;
    logic [WQ-1:0] r_qquo;
    logic [WS-1:0] r_mquo;
    logic [SB-1:0] r_span;
    logic [TW-1:0] r_count;
    logic          r_ovf;

    logic [TW:0]   w_qsh, w_qdiff, w_msh, w_mdiff, w_den;
    logic          w_qge, w_mge;

    // square root state
    logic [2*SB-1:0] r_rad;
    logic [SB-1:0]   r_root;
    logic [SB+1:0]   r_srem;
    logic [SB+3:0]   w_trial, w_cand, w_tdiff;
    logic            w_tge;

    logic            r_out_valid;
    t_out_item       r_out;

    logic [WS+SAMPLE_W-1:0] w_mean_ext;
    logic [SB+SAMPLE_W-1:0] w_span_ext, w_rms_ext;
    logic [TW+COUNT_W-1:0]  w_cnt_ext;

    always_comb begin
        w_s    = i_sample[SB-1:0];
        w_b    = r_dc_bias[SB-1:0];
        w_dev  = (w_s >= w_b) ? (w_s - w_b) : (w_b - w_s);
        w_prod = {{SB{1'b0}}, w_dev} * {{SB{1'b0}}, w_dev};
        w_full = (r_tally >= MAX_T);

        n_sum   = r_sum;
        n_sq    = r_sq;
        n_min   = r_min;
        n_max   = r_max;
        n_tally = r_tally;
        n_sat   = r_sat | w_full;
        // drop samples once the count is saturated
        if (!w_full) begin
            n_sum   = r_sum + WS'(w_s);
            n_sq    = r_sq + WQ'(w_prod);
            n_min   = (w_s < r_min) ? w_s : r_min;
            n_max   = (w_s > r_max) ? w_s : r_max;
            n_tally = r_tally + 1'b1;
        end
    end

    always_comb begin
        w_den   = {1'b0, r_div_n};
        w_qsh   = {r_qrem, r_qquo[WQ-1]};
        w_qge   = (w_qsh >= w_den);
        w_qdiff = w_qsh - w_den;
        w_msh   = {r_mrem, r_mquo[WS-1]};
        w_mge   = (w_msh >= w_den);
        w_mdiff = w_msh - w_den;

        w_trial = {r_srem, r_rad[2*SB-1 -: 2]};
        w_cand  = {2'b00, r_root, 2'b01};
        w_tge   = (w_trial >= w_cand);
        w_tdiff = w_trial - w_cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_bias <= '0;
        end else if (i_cfg_valid) begin
            r_dc_bias <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sq    <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_tally <= '0;
            r_sat   <= 1'b0;
        end else if (i_cmd.acc) begin
            if (i_cmd.load) begin
                r_sum   <= '0;
                r_sq    <= '0;
                r_min   <= '1;
                r_max   <= '0;
                r_tally <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_sq    <= n_sq;
                r_min   <= n_min;
                r_max   <= n_max;
                r_tally <= n_tally;
                r_sat   <= n_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div_n <= n_tally;
            r_qrem  <= '0;
            r_qquo  <= n_sq;
            r_mrem  <= '0;
            r_mquo  <= n_sum;
            r_span  <= n_max - n_min;
            r_count <= n_tally;
            r_ovf   <= n_sat;
        end else if (i_cmd.div_step) begin
            r_qrem <= w_qge ? w_qdiff[TW-1:0] : w_qsh[TW-1:0];
            r_qquo <= {r_qquo[WQ-2:0], w_qge};
            if (i_cmd.mean_step) begin
                r_mrem <= w_mge ? w_mdiff[TW-1:0] : w_msh[TW-1:0];
                r_mquo <= {r_mquo[WS-2:0], w_mge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_load) begin
            // mean square stays below 2^(2*SB)
            r_rad  <= r_qquo[2*SB-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.root_step) begin
            r_rad  <= {r_rad[2*SB-3:0], 2'b00};
            r_srem <= w_tge ? w_tdiff[SB+1:0] : w_trial[SB+1:0];
            r_root <= {r_root[SB-2:0], w_tge};
        end
    end

    assign w_mean_ext = {{SAMPLE_W{1'b0}}, r_mquo};
    assign w_span_ext = {{SAMPLE_W{1'b0}}, r_span};
    assign w_rms_ext  = {{SAMPLE_W{1'b0}}, r_root};
    assign w_cnt_ext  = {{COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.mean_level    <= w_mean_ext[SAMPLE_W-1:0];
            r_out.span          <= w_span_ext[SAMPLE_W-1:0];
            r_out.rms_level     <= w_rms_ext[SAMPLE_W-1:0];
            r_out.samples_seen  <= w_cnt_ext[COUNT_W-1:0];
            r_out.overflow_flag <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule
`default_nettype wire

// File: hdl/abls_checker.sv
`default_nettype none
module abls_checker
    import abls_pkg::*;
#(
    parameter int MAX_COUNT = ABLS_MAX_COUNT
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_item  i_data,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_data
);

    localparam logic [31:0] MAX_W = 32'(MAX_COUNT);
    localparam logic [COUNT_W-1:0] MAX_SEEN = MAX_W[COUNT_W-1:0];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // the end of a buffer stops the input while the result is computed
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.end_of_buffer |=> !o_ready)
        else $error("input ready right after end of buffer");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (MAX_SEEN != '0) |-> o_data.samples_seen != '0)
        else $error("result with zero samples");

    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.overflow_flag |-> o_data.samples_seen == MAX_SEEN)
        else $error("overflow flag without saturated count");

endmodule

bind audio_buffer_level_stats_unit abls_checker #(
    .MAX_COUNT (MAX_COUNT)
) u_abls_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
`default_nettype wire
